FILE: hw/rtl/tdma_slot_clock_sync_macros.svh
// Assertion macros shared by the TDMA slot timer.
`ifndef TDMA_SLOT_CLOCK_SYNC_MACROS_SVH
`define TDMA_SLOT_CLOCK_SYNC_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define TSC_ASSERT_NOW(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("tdma_slot_clock_sync assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define TSC_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("tdma_slot_clock_sync assertion failed");

`endif

FILE: hw/rtl/tsc_pkg.sv
// Types and constants shared by the TDMA slot timer modules.
package tsc_pkg;

	// Divider geometry: 64-bit dividend, 32-bit divisor, one bit per cycle.
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 32;
	localparam int DIV_STEPS  = 64;
	localparam int DIV_CNT_W  = 6;

	// Division by 1000 in 16-bit digits: a digit step divides a value below
	// 1000 * 2^16 by multiplying with ceil(2^36 / 1000) and shifting by 36.
	localparam logic [26:0] RECIP_1000  = 27'd68719477;
	localparam int          RECIP_SHIFT = 36;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SLOT_PERIOD  = 3'd0;
	localparam logic [2:0] REG_SLOT_COUNT   = 3'd1;
	localparam logic [2:0] REG_ANCHOR_ROLE  = 3'd2;
	localparam logic [2:0] REG_OWN_SLOT     = 3'd3;
	localparam logic [2:0] REG_OFFSET_LIMIT = 3'd4;
	localparam logic [2:0] REG_HEIGHT_A     = 3'd5;
	localparam logic [2:0] REG_HEIGHT_B     = 3'd6;

	// Slot action codes.
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_PULSE  = 2'd1;
	localparam logic [1:0] ACT_HEIGHT = 2'd2;
	localparam logic [1:0] ACT_SAMPLE = 2'd3;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quot;
		logic [DIVISOR_W-1:0]  rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FS_DIV,
		ST_DR_DIV,
		ST_CHECK,
		ST_SLOT_DIV1,
		ST_SLOT_DIV2,
		ST_ACTION,
		ST_MUL,
		ST_CORR_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/tsc_div.sv
// Shared restoring divider, unsigned 64 by 32 bits, one quotient bit per cycle.
module tsc_div import tsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dv_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// One restoring step on the partial remainder.
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dv_q};
		ge    = (trial >= {1'b0, dv_q});
	end

	// Control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dv_q   <= req.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: hw/rtl/tdma_slot_clock_sync.sv
// TDMA slot timer with clock synchronization and drift correction, top level.
// A sync message runs the shared 64-step divider when it is the first sync or when it
// updates the drift, and does not run it when it is rejected. A slot compare adds two
// passes through the shared divider (slot remainder and slot index) and a division by
// 1000 in 16-bit digits for the drift correction. The block takes one item at a time;
// a finished result waits in the output register while the next item is accepted.
module tdma_slot_clock_sync import tsc_pkg::*; #(
	parameter int MAX_SLOTS     = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] local_stamp,
	input  logic [31:0] master_stamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        slot_fired,
	output logic [3:0]  slot_number,
	output logic [1:0]  slot_action,
	output logic        sample_buffer,
	output logic [3:0]  previous_sample_slot,
	output logic        in_sync,
	output logic signed [31:0] sync_error,
	output logic signed [31:0] worst_error,
	output logic [31:0] time_now,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "tdma_slot_clock_sync_macros.svh"

	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_W = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;

	// Configuration registers.
	logic [19:0] cfg_period_q;
	logic [4:0]  cfg_count_q;
	logic        cfg_anchor_q;
	logic [3:0]  cfg_own_q;
	logic [19:0] cfg_limit_q;
	logic [3:0]  cfg_ha_q;
	logic [3:0]  cfg_hb_q;

	// Timer state.
	state_t             state_q, state_d;
	logic [31:0]        time_q, cmp_q, last_q, base_q;
	logic               sync_q;
	logic [1:0]         bad_q;
	logic signed [31:0] rate_q, resid_q, lerr_q, werr_q;
	logic               bsel_q;
	logic [3:0]         older_q, newer_q;
	logic               req_q;
	logic [31:0]        ls_q, ms_q;
	logic               neg_q;
	logic [SLOT_W-1:0]  slot_q;
	logic signed [52:0] prod_q;
	logic               fired_q, buf_q;
	logic [3:0]         num_q;
	logic [1:0]         act_q;

	// Digit division by 1000 for the drift correction.
	logic [1:0]         dg_cnt_q;
	logic               dg_ph_q;
	logic [9:0]         dg_rem_q;
	logic [15:0]        dg_qd_q;
	logic [63:0]        dg_quo_q;

	// Output registers.
	logic               out_valid_q, o_fired_q, o_buf_q, o_sync_q;
	logic [3:0]         o_num_q, o_prev_q;
	logic [1:0]         o_act_q;
	logic signed [31:0] o_serr_q, o_werr_q;
	logic [31:0]        o_time_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	tsc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Derived values used by the sequencer.
	logic [31:0]        p32, raw, err_mag, werr_mag, local_t, elapsed, tick_t, fs_base;
	logic [31:0]        frame, nxt_cmp;
	logic [CNT_W-1:0]   eff_cnt;
	logic signed [31:0] err;
	logic               accept_sync, can_out;
	logic [63:0]        drift_num, prod_mag;
	logic [65:0]        rate_sum, q_ext;
	logic signed [63:0] div_term, acc, corr, half;
	logic [15:0]        dg_digit, dg_qd;
	logic [25:0]        dg_num, dg_back, dg_diff;
	logic [52:0]        dg_prod;

	always_comb begin
		p32      = (cfg_period_q == 20'd0) ? 32'd1 : {12'd0, cfg_period_q};
		if (cfg_count_q < 5'd2)
			eff_cnt = CNT_W'(2);
		else if (32'(cfg_count_q) > 32'(MAX_SLOTS))
			eff_cnt = CNT_W'(MAX_SLOTS);
		else
			eff_cnt = CNT_W'(cfg_count_q);
		frame    = 32'(eff_cnt) * p32;
		raw      = ls_q - ms_q;
		err      = signed'(raw);
		err_mag  = raw[31] ? (32'd0 - raw) : raw;
		werr_mag = werr_q[31] ? (32'd0 - unsigned'(werr_q)) : unsigned'(werr_q);
		local_t  = time_q - raw;
		elapsed  = local_t - last_q;
		tick_t   = time_q + 32'd1;
		fs_base  = local_t + (p32 << 1);
		nxt_cmp  = cmp_q + p32;
		accept_sync = (err_mag < {12'd0, cfg_limit_q});
		// err_mag * 1000 as shifts, then scaled to the fraction format.
		drift_num = ((64'(err_mag) << 10) - (64'(err_mag) << 4) - (64'(err_mag) << 3))
			<< FRACTION_BITS;
		prod_mag = prod_q[52] ? 64'(-prod_q) : 64'(prod_q);
		// Drift rate update, saturated to 32 signed bits.
		q_ext    = neg_q ? (66'd0 - {2'd0, div_rsp.quot}) : {2'd0, div_rsp.quot};
		rate_sum = {{34{rate_q[31]}}, rate_q} + q_ext;
		// One digit of the division by 1000, most significant digit first.
		case (dg_cnt_q)
			2'd0:    dg_digit = prod_mag[63:48];
			2'd1:    dg_digit = prod_mag[47:32];
			2'd2:    dg_digit = prod_mag[31:16];
			default: dg_digit = prod_mag[15:0];
		endcase
		dg_num  = {dg_rem_q, dg_digit};
		dg_prod = 53'(dg_num) * 53'(RECIP_1000);
		dg_qd   = dg_prod[RECIP_SHIFT+15:RECIP_SHIFT];
		dg_back = (26'(dg_qd_q) << 10) - (26'(dg_qd_q) << 4) - (26'(dg_qd_q) << 3);
		dg_diff = dg_num - dg_back;
		// Correction step with rounding half away from zero.
		div_term = prod_q[52] ? -signed'(dg_quo_q) : signed'(dg_quo_q);
		acc      = 64'(resid_q) + div_term;
		half     = 64'sd1 <<< (FRACTION_BITS - 1);
		if (acc >= 0)
			corr = (acc + half) >>> FRACTION_BITS;
		else
			corr = -((-acc + half) >>> FRACTION_BITS);
		can_out  = !out_valid_q || !out_stall;
	end

	// Sequencer next state and divider requests.
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = 64'(cmp_q);
		div_req.divisor  = frame;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!req_q) begin
					if (tick_t == cmp_q) begin
						div_req.start = 1'b1;
						state_d = ST_SLOT_DIV1;
					end else begin
						state_d = ST_DONE;
					end
				end else if (!sync_q) begin
					div_req.start    = 1'b1;
					div_req.dividend = 64'(fs_base);
					div_req.divisor  = p32;
					state_d = ST_FS_DIV;
				end else if (accept_sync) begin
					if (elapsed != 32'd0) begin
						div_req.start    = 1'b1;
						div_req.dividend = drift_num;
						div_req.divisor  = elapsed;
						state_d = ST_DR_DIV;
					end else begin
						state_d = ST_CHECK;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FS_DIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DR_DIV: begin
				if (div_rsp.done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (time_q >= cmp_q) begin
					div_req.start = 1'b1;
					state_d = ST_SLOT_DIV1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SLOT_DIV1: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = 64'(div_rsp.rem);
					div_req.divisor  = p32;
					state_d = ST_SLOT_DIV2;
				end
			end
			ST_SLOT_DIV2: begin
				if (div_rsp.done) state_d = ST_ACTION;
			end
			ST_ACTION: state_d = ST_MUL;
			ST_MUL: state_d = ST_CORR_DIV;
			ST_CORR_DIV: begin
				if (dg_ph_q && (dg_cnt_q == 2'd3)) state_d = ST_APPLY;
			end
			ST_APPLY: state_d = ST_DONE;
			ST_DONE: begin
				if (can_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q <= 20'd50000;
			cfg_count_q  <= 5'd6;
			cfg_anchor_q <= 1'b0;
			cfg_own_q    <= 4'd0;
			cfg_limit_q  <= 20'd1000;
			cfg_ha_q     <= 4'd2;
			cfg_hb_q     <= 4'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SLOT_PERIOD:  cfg_period_q <= cfg_data[19:0];
				REG_SLOT_COUNT:   cfg_count_q  <= cfg_data[4:0];
				REG_ANCHOR_ROLE:  cfg_anchor_q <= cfg_data[0];
				REG_OWN_SLOT:     cfg_own_q    <= cfg_data[3:0];
				REG_OFFSET_LIMIT: cfg_limit_q  <= cfg_data[19:0];
				REG_HEIGHT_A:     cfg_ha_q     <= cfg_data[3:0];
				REG_HEIGHT_B:     cfg_hb_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Timer datapath, advanced by the sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			cmp_q    <= 32'd50000;
			sync_q   <= 1'b0;
			bad_q    <= '0;
			rate_q   <= '0;
			resid_q  <= '0;
			last_q   <= '0;
			lerr_q   <= '0;
			werr_q   <= '0;
			bsel_q   <= 1'b0;
			older_q  <= '0;
			newer_q  <= '0;
			base_q   <= '0;
			req_q    <= 1'b0;
			ls_q     <= '0;
			ms_q     <= '0;
			neg_q    <= 1'b0;
			slot_q   <= '0;
			prod_q   <= '0;
			fired_q  <= 1'b0;
			num_q    <= '0;
			act_q    <= ACT_NONE;
			buf_q    <= 1'b0;
			dg_cnt_q <= '0;
			dg_ph_q  <= 1'b0;
			dg_rem_q <= '0;
			dg_qd_q  <= '0;
			dg_quo_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						ls_q    <= local_stamp;
						ms_q    <= master_stamp;
						fired_q <= 1'b0;
						num_q   <= '0;
						act_q   <= ACT_NONE;
						buf_q   <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (!req_q) begin
						time_q <= tick_t;
						if (tick_t == cmp_q) begin
							fired_q <= 1'b1;
							cmp_q   <= (nxt_cmp > cmp_q) ? nxt_cmp : p32;
						end
					end else if (!sync_q) begin
						time_q <= local_t;
						base_q <= fs_base;
						sync_q <= 1'b1;
						lerr_q <= '0;
						bad_q  <= '0;
					end else if (accept_sync) begin
						lerr_q <= err;
						last_q <= local_t;
						time_q <= local_t;
						bad_q  <= '0;
						neg_q  <= err[31];
						if (err_mag > werr_mag) werr_q <= err;
					end else begin
						lerr_q <= err;
						if (bad_q != 2'd0) begin
							bad_q  <= 2'd2;
							sync_q <= 1'b0;
							rate_q <= '0;
							time_q <= '0;
						end else begin
							bad_q <= 2'd1;
						end
					end
				end
				ST_FS_DIV: begin
					if (div_rsp.done) cmp_q <= base_q - div_rsp.rem;
				end
				ST_DR_DIV: begin
					if (div_rsp.done) begin
						if (signed'(rate_sum) > 66'sd2147483647)
							rate_q <= 32'sh7FFFFFFF;
						else if (signed'(rate_sum) < -66'sd2147483648)
							rate_q <= 32'sh80000000;
						else
							rate_q <= signed'(rate_sum[31:0]);
					end
				end
				ST_CHECK: begin
					if (time_q >= cmp_q) begin
						fired_q <= 1'b1;
						cmp_q   <= (nxt_cmp > cmp_q) ? nxt_cmp : p32;
					end
				end
				ST_SLOT_DIV2: begin
					if (div_rsp.done) slot_q <= div_rsp.quot[SLOT_W-1:0];
				end
				ST_ACTION: begin
					num_q  <= 4'(slot_q);
					prod_q <= 53'(rate_q) * 53'(signed'({1'b0, p32[19:0]}));
					if (cfg_anchor_q) begin
						if ((32'(slot_q) == 32'(cfg_own_q)) && sync_q) act_q <= ACT_PULSE;
					end else if ((32'(slot_q) == 32'(cfg_ha_q)) ||
							(32'(slot_q) == 32'(cfg_hb_q))) begin
						act_q <= ACT_HEIGHT;
					end else begin
						act_q   <= ACT_SAMPLE;
						buf_q   <= bsel_q;
						bsel_q  <= ~bsel_q;
						older_q <= newer_q;
						newer_q <= 4'(slot_q);
					end
				end
				ST_MUL: begin
					dg_cnt_q <= '0;
					dg_ph_q  <= 1'b0;
					dg_rem_q <= '0;
					dg_quo_q <= '0;
				end
				// Each digit has a quotient phase and then a remainder phase.
				ST_CORR_DIV: begin
					if (!dg_ph_q) begin
						dg_qd_q <= dg_qd;
						dg_ph_q <= 1'b1;
					end else begin
						dg_rem_q <= dg_diff[9:0];
						dg_quo_q <= {dg_quo_q[47:0], dg_qd_q};
						dg_cnt_q <= dg_cnt_q + 2'd1;
						dg_ph_q  <= 1'b0;
					end
				end
				ST_APPLY: begin
					time_q  <= time_q - corr[31:0];
					resid_q <= signed'(32'(acc - (corr <<< FRACTION_BITS)));
				end
				default: ;
			endcase
		end
	end

	// Output register; the next item may start while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			o_fired_q   <= 1'b0;
			o_num_q     <= '0;
			o_act_q     <= ACT_NONE;
			o_buf_q     <= 1'b0;
			o_prev_q    <= '0;
			o_sync_q    <= 1'b0;
			o_serr_q    <= '0;
			o_werr_q    <= '0;
			o_time_q    <= '0;
		end else if (state_q == ST_DONE && can_out) begin
			out_valid_q <= 1'b1;
			o_fired_q   <= fired_q;
			o_num_q     <= num_q;
			o_act_q     <= act_q;
			o_buf_q     <= buf_q;
			o_prev_q    <= older_q;
			o_sync_q    <= sync_q;
			o_serr_q    <= lerr_q;
			o_werr_q    <= werr_q;
			o_time_q    <= time_q;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign slot_fired           = o_fired_q;
	assign slot_number          = o_num_q;
	assign slot_action          = o_act_q;
	assign sample_buffer        = o_buf_q;
	assign previous_sample_slot = o_prev_q;
	assign in_sync              = o_sync_q;
	assign sync_error           = o_serr_q;
	assign worst_error          = o_werr_q;
	assign time_now             = o_time_q;

	// An action is only ever reported together with a fired compare.
	`TSC_ASSERT_NOW(a_action_fired, out_valid && (slot_action != ACT_NONE), slot_fired)
	// A buffer index is only reported with a sampling action.
	`TSC_ASSERT_NOW(a_buf_sample, out_valid && sample_buffer, slot_action == ACT_SAMPLE)
	// The divider runs only while the sequencer waits on it.
	`TSC_ASSERT_NOW(a_div_owner, div_rsp.busy,
		(state_q == ST_FS_DIV) || (state_q == ST_DR_DIV) || (state_q == ST_SLOT_DIV1) ||
		(state_q == ST_SLOT_DIV2))
	// A waiting result is not overwritten by the next item.
	`TSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(time_now) && out_valid)

endmodule

FILE: tb/tdma_slot_clock_sync_tb.sv
// Self-checking testbench for the TDMA slot timer with clock sync and drift correction.
module tdma_slot_clock_sync_tb;
	import tsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF   = 6;
	localparam int          IDLE_LIMIT = 4000;
	localparam int          SETTLE     = 300;
	localparam logic [2:0]  REG_SPARE  = 3'd7;
	localparam logic        REQ_TICK   = 1'b0;
	localparam logic        REQ_SYNC   = 1'b1;
	localparam int          FRAC       = 16;
	localparam longint      HALF_TICK  = 64'sd1 <<< (FRAC - 1);

	// One slot timer result as seen on the output port.
	typedef struct {
		logic               fired;
		logic [3:0]         number;
		logic [1:0]         action;
		logic               buffer;
		logic [3:0]         prev_slot;
		logic               synced;
		logic signed [31:0] err;
		logic signed [31:0] worst;
		logic [31:0]        now;
	} slot_result_t;

	// Timer predictor with its own copy of registers and state, plus the
	// queue of results still owed by the block.
	class slot_timer_scoreboard;
		bit [19:0] period_reg;
		bit [4:0]  count_reg;
		bit        anchor;
		bit [3:0]  own;
		bit [19:0] limit_reg;
		bit [3:0]  height_a;
		bit [3:0]  height_b;

		bit [31:0] counter;
		bit [31:0] next_cmp;
		bit        synced;
		bit [1:0]  bad_msgs;
		int        rate;
		int        residue;
		bit [31:0] last_upd;
		int        latest_err;
		int        largest_err;
		bit        buf_sel;
		bit [3:0]  older_slot;
		bit [3:0]  newer_slot;

		slot_result_t owed[$];
		int errors;
		int items;
		int fires;
		int drops;

		function new();
			period_reg = 50000; count_reg = 6; anchor = 0; own = 0;
			limit_reg = 1000; height_a = 2; height_b = 5;
			counter = 0; next_cmp = 50000; synced = 0; bad_msgs = 0;
			rate = 0; residue = 0; last_upd = 0; latest_err = 0; largest_err = 0;
			buf_sel = 0; older_slot = 0; newer_slot = 0;
		endfunction

		function bit [31:0] eff_period();
			return (period_reg == 0) ? 32'd1 : 32'(period_reg);
		endfunction

		function bit [31:0] eff_count();
			if (count_reg < 2) return 2;
			if (count_reg > 16) return 16;
			return 32'(count_reg);
		endfunction

		function bit [31:0] mag(int v);
			return v[31] ? (32'd0 - 32'(v)) : 32'(v);
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_SLOT_PERIOD:  period_reg = val[19:0];
				REG_SLOT_COUNT:   count_reg = val[4:0];
				REG_ANCHOR_ROLE:  anchor = val[0];
				REG_OWN_SLOT:     own = val[3:0];
				REG_OFFSET_LIMIT: limit_reg = val[19:0];
				REG_HEIGHT_A:     height_a = val[3:0];
				REG_HEIGHT_B:     height_b = val[3:0];
				default: ;
			endcase
		endfunction

		// Slot compare: number, action, ping-pong buffer and drift correction.
		function void fire_slot(ref slot_result_t r);
			bit [31:0] p, cur, nxt, slot;
			longint acc, corr;
			p = eff_period();
			cur = next_cmp;
			nxt = cur + p;
			next_cmp = (nxt > cur) ? nxt : p;
			slot = (cur % (eff_count() * p)) / p;
			r.fired = 1;
			r.number = slot[3:0];
			if (anchor) begin
				if (slot == 32'(own) && synced) r.action = ACT_PULSE;
			end else if (slot == 32'(height_a) || slot == 32'(height_b)) begin
				r.action = ACT_HEIGHT;
			end else begin
				r.action = ACT_SAMPLE;
				r.buffer = buf_sel;
				buf_sel = ~buf_sel;
				older_slot = newer_slot;
				newer_slot = slot[3:0];
			end
			acc = longint'(residue) + (longint'(rate) * longint'(p)) / 1000;
			if (acc >= 0) corr = (acc + HALF_TICK) >>> FRAC;
			else corr = -((-acc + HALF_TICK) >>> FRAC);
			counter = counter - corr[31:0];
			residue = int'(acc - corr * (64'sd1 <<< FRAC));
			fires++;
		endfunction

		// Work out the result of an accepted item and queue it.
		function void note_input(logic rt, logic [31:0] ls, logic [31:0] ms);
			slot_result_t r;
			bit [31:0] raw, local_t, p, elapsed;
			int err;
			longint q, sum;
			r = '{default: '0};
			items++;
			if (rt == REQ_TICK) begin
				counter = counter + 1;
				if (counter == next_cmp) fire_slot(r);
			end else begin
				raw = ls - ms;
				err = int'(raw);
				local_t = counter - raw;
				p = eff_period();
				latest_err = err;
				if (!synced) begin
					counter = local_t;
					next_cmp = local_t + 2 * p;
					next_cmp = next_cmp - next_cmp % p;
					synced = 1;
					latest_err = 0;
					bad_msgs = 0;
				end else if (mag(err) < 32'(limit_reg)) begin
					elapsed = local_t - last_upd;
					if (elapsed != 0) begin
						q = (longint'(err) * 1000 * (64'sd1 <<< FRAC)) / longint'(elapsed);
						sum = longint'(rate) + q;
						if (sum > 64'sd2147483647) rate = 32'sh7FFFFFFF;
						else if (sum < -64'sd2147483648) rate = 32'sh80000000;
						else rate = int'(sum);
					end
					last_upd = local_t;
					counter = local_t;
					if (local_t >= next_cmp) fire_slot(r);
					bad_msgs = 0;
					if (mag(err) > mag(largest_err)) largest_err = err;
				end else begin
					if (bad_msgs < 2) bad_msgs++;
					if (bad_msgs >= 2) begin
						if (synced) drops++;
						synced = 0;
						rate = 0;
						counter = 0;
					end
				end
			end
			r.prev_slot = older_slot;
			r.synced = synced;
			r.err = latest_err;
			r.worst = largest_err;
			r.now = counter;
			owed.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// Compare one result from the block with the oldest expectation.
		task check_result(slot_result_t got);
			slot_result_t exp;
			if (owed.size() == 0) begin
				report("result arrived with no item waiting");
				return;
			end
			exp = owed.pop_front();
			if (got.fired !== exp.fired)
				report($sformatf("slot_fired %0b, expected %0b", got.fired, exp.fired));
			if (got.number !== exp.number)
				report($sformatf("slot_number %0d, expected %0d", got.number, exp.number));
			if (got.action !== exp.action)
				report($sformatf("slot_action %0d, expected %0d", got.action, exp.action));
			if (got.buffer !== exp.buffer)
				report($sformatf("sample_buffer %0b, expected %0b", got.buffer, exp.buffer));
			if (got.prev_slot !== exp.prev_slot)
				report($sformatf("previous_sample_slot %0d, expected %0d",
					got.prev_slot, exp.prev_slot));
			if (got.synced !== exp.synced)
				report($sformatf("in_sync %0b, expected %0b", got.synced, exp.synced));
			if (got.err !== exp.err)
				report($sformatf("sync_error %0d, expected %0d", got.err, exp.err));
			if (got.worst !== exp.worst)
				report($sformatf("worst_error %0d, expected %0d", got.worst, exp.worst));
			if (got.now !== exp.now)
				report($sformatf("time_now %h, expected %h", got.now, exp.now));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [31:0] local_stamp;
	logic [31:0] master_stamp;
	logic        out_valid;
	logic        out_stall;
	logic        slot_fired;
	logic [3:0]  slot_number;
	logic [1:0]  slot_action;
	logic        sample_buffer;
	logic [3:0]  previous_sample_slot;
	logic        in_sync;
	logic signed [31:0] sync_error;
	logic signed [31:0] worst_error;
	logic [31:0] time_now;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	slot_timer_scoreboard sb;
	bit quiet;
	int idle_cycles;

	tdma_slot_clock_sync dut (.*);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(slot_result_t'{slot_fired, slot_number, slot_action,
				sample_buffer, previous_sample_slot, in_sync, sync_error, worst_error,
				time_now});
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stall before each result, none in quiet phases.
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Present one register write; the caller lowers cfg_valid after the last one.
	task write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// Present one item after a random gap, none in quiet phases, and wait until it is taken.
	task send_item(logic rt, logic [31:0] ls, logic [31:0] ms);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		local_stamp <= ls;
		master_stamp <= ms;
		do @(posedge clk); while (in_stall);
		sb.note_input(rt, ls, ms);
	endtask

	task wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.owed.size() != 0);
	endtask

	// Sync message whose error is e.
	task send_sync(int e);
		logic [31:0] ms;
		ms = $urandom;
		send_item(REQ_SYNC, ms + 32'(e), ms);
	endtask

	// Mostly ticks and in-limit syncs, with bad messages, forced drops and noise.
	task random_items(int n);
		int r, emax, emin, e;
		bit [31:0] p, lim;
		for (int k = 0; k < n; k++) begin
			p = sb.eff_period();
			lim = 32'(sb.limit_reg);
			if (k == n / 2) wait_results();
			r = $urandom_range(0, 99);
			if (k % 45 == 44) begin
				send_sync(int'(lim) + 5);
				send_sync(-int'(lim) - 7);
				send_sync($urandom_range(0, 100));
			end else if (r < 70) begin
				send_item(REQ_TICK, $urandom, $urandom);
			end else if (r < 88) begin
				emax = (lim > 41) ? 40 : int'(lim) - 1;
				emin = -(((p / 2) < 32'(emax)) ? int'(p / 2) : emax);
				e = int'($urandom_range(0, emax - emin)) + emin;
				send_sync(e);
			end else if (r < 95) begin
				e = int'(lim) + int'($urandom_range(0, 1000));
				send_sync($urandom_range(0, 1) ? e : -e);
			end else begin
				send_item(REQ_SYNC, $urandom, $urandom);
			end
		end
	endtask

	task directed_items();
		send_item(REQ_TICK, 32'h0, 32'h0);
		send_item(REQ_SYNC, 32'h10, 32'h0);
		send_item(REQ_SYNC, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(REQ_SYNC, 32'hFFFFFFFF, 32'hFFFFFFFF);
		repeat (16) send_item(REQ_TICK, 32'hFFFFFFFF, 32'h0);
		send_item(REQ_SYNC, 32'd5, 32'd0);
		send_item(REQ_SYNC, 32'd0, 32'd3);
		send_item(REQ_SYNC, 32'h80000000, 32'h0);
		send_item(REQ_SYNC, 32'h7FFFFFFF, 32'h0);
		send_item(REQ_SYNC, 32'h0, 32'h0);
	endtask

	// Register settings per phase: period, count, role, own, limit, height a, height b.
	int cfg_set[8][7] = '{
		'{7,       4,  0, 0,  1000000, 1,  3},
		'{1,       2,  1, 0,  1,       0,  1},
		'{0,       0,  0, 5,  200,     15, 0},
		'{13,      16, 1, 15, 500,     2,  5},
		'{25,      31, 0, 9,  64,      4,  14},
		'{1000000, 6,  1, 3,  1000000, 2,  5},
		'{5,       3,  1, 1,  100,     0,  2},
		'{40,      9,  0, 7,  300,     3,  8}
	};

	initial begin
		sb = new();
		quiet = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_TICK;
		local_stamp <= '0;
		master_stamp <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SLOT_PERIOD;
		cfg_data <= '0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 3 || ph == 6);
			write_reg(REG_SLOT_PERIOD, cfg_set[ph][0]);
			write_reg(REG_SLOT_COUNT, cfg_set[ph][1]);
			write_reg(REG_ANCHOR_ROLE, cfg_set[ph][2]);
			write_reg(REG_OWN_SLOT, cfg_set[ph][3]);
			write_reg(REG_OFFSET_LIMIT, cfg_set[ph][4]);
			write_reg(REG_HEIGHT_A, cfg_set[ph][5]);
			write_reg(REG_HEIGHT_B, cfg_set[ph][6]);
			if (ph == 2) write_reg(REG_SPARE, 32'hFFFFFFFF);
			cfg_valid <= 1'b0;
			if (ph == 0) directed_items();
			random_items((ph == 5) ? 40 : 200);
			wait_results();
			repeat (SETTLE) @(posedge clk);
		end

		$display("Covered %0d items over 8 register settings: %0d slot compares, %0d sync drops.",
			sb.items, sb.fires, sb.drops);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_div.sv
hw/rtl/tdma_slot_clock_sync.sv
tb/tdma_slot_clock_sync_tb.sv
